FILE: rtl/analog_keypad_debouncer_top_macros.svh
// ---------------------------------------------------------------------------
// analog_keypad_debouncer_top_macros
// assertion macros shared by the keypad debouncer rtl
// ---------------------------------------------------------------------------
`ifndef ANALOG_KEYPAD_DEBOUNCER_TOP_MACROS_SVH
`define ANALOG_KEYPAD_DEBOUNCER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define AKD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AKD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/akd_pkg.sv
// ---------------------------------------------------------------------------
// akd_pkg
// types and constants for the analog keypad debouncer
// ---------------------------------------------------------------------------
package akd_pkg;

    localparam int NUM_KEYS    = 5;
    localparam int LEVEL_SLOTS = 5;

    localparam int SAMPLE_W    = 10;
    localparam int TIME_W      = 32;
    localparam int DEBOUNCE_W  = 8;
    localparam int KEY_W       = 4;
    localparam int KEY_IDX_W   = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    typedef logic signed [KEY_W-1:0] key_t;

    localparam key_t NO_KEY = -4'sd1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_KEY0   = 3'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd10;
    localparam logic [SAMPLE_W-1:0]   WINDOW_RESET   = 10'd10;

    typedef logic [SAMPLE_W-1:0] level_arr_t [LEVEL_SLOTS];

    typedef struct packed {
        key_t                 settled_key;
        logic                 press_event;
        logic [KEY_IDX_W-1:0] pressed_key;
        logic                 release_event;
        logic [KEY_IDX_W-1:0] released_key;
    } result_t;

endpackage

FILE: rtl/akd_matcher.sv
// ---------------------------------------------------------------------------
// akd_matcher
// maps one sample to the lowest key whose level lies within the window
// ---------------------------------------------------------------------------
module akd_matcher import akd_pkg::*; (
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SAMPLE_W-1:0] match_window,
    input  level_arr_t          levels,
    output key_t                raw_key
);

    logic [NUM_KEYS-1:0] hit;

    // one distance compare per key, all in parallel
    always_comb begin
        for (int i = 0; i < NUM_KEYS; i++) begin
            logic [SAMPLE_W-1:0] gap;
            gap    = (sample >= levels[i]) ? (sample - levels[i]) : (levels[i] - sample);
            hit[i] = (gap <= match_window);
        end
    end

    // lowest index wins
    always_comb begin
        raw_key = NO_KEY;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                raw_key = key_t'(i);
            end
        end
    end

endmodule

FILE: rtl/akd_tracker.sv
// ---------------------------------------------------------------------------
// akd_tracker
// debounce state: stable key, previous raw key and change timestamp
// ---------------------------------------------------------------------------
module akd_tracker import akd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  key_t                  raw_key,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic [DEBOUNCE_W-1:0] debounce_ms,
    output result_t               result
);

    key_t              settled_key_reg, settled_key_next;
    key_t              prev_raw_reg,    prev_raw_next;
    logic [TIME_W-1:0] change_time_reg, change_time_next;

    logic [TIME_W-1:0] elapsed;
    logic              commit;

    assign elapsed = now_ms - change_time_reg;

    always_comb begin
        settled_key_next = settled_key_reg;
        prev_raw_next    = prev_raw_reg;
        change_time_next = change_time_reg;
        commit           = 1'b0;
        if (raw_key != settled_key_reg) begin
            if (raw_key == prev_raw_reg) begin
                // wrapping elapsed time, strictly longer than the hold time
                if (elapsed > {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms}) begin
                    commit           = 1'b1;
                    settled_key_next = raw_key;
                end
            end else begin
                prev_raw_next    = raw_key;
                change_time_next = now_ms;
            end
        end
    end

    always_comb begin
        result.settled_key   = settled_key_next;
        result.release_event = commit && (settled_key_reg != NO_KEY);
        result.released_key  = result.release_event ? settled_key_reg[KEY_IDX_W-1:0] : '0;
        result.press_event   = commit && (raw_key != NO_KEY);
        result.pressed_key   = result.press_event ? raw_key[KEY_IDX_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settled_key_reg <= NO_KEY;
            prev_raw_reg    <= NO_KEY;
            change_time_reg <= '0;
        end else if (step) begin
            settled_key_reg <= settled_key_next;
            prev_raw_reg    <= prev_raw_next;
            change_time_reg <= change_time_next;
        end
    end

endmodule

FILE: rtl/analog_keypad_debouncer_top.sv
// ---------------------------------------------------------------------------
// analog_keypad_debouncer_top
// resistor ladder keypad: sample to key match, debounce, press and release
// ---------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_adc_sample, s_now_ms
// m_        out  m_valid/m_ready    stable key, press and release events
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata
//
// one word per cycle while m_ready holds; m_valid rises when out_reg is loaded
// the match, the timer subtract and the state update are combinational
// between the input register and the result register
// reset needs no clearing pass
// a stalled m_ side holds one word in each register before s_ready drops
// ---------------------------------------------------------------------------
`include "analog_keypad_debouncer_top_macros.svh"

module analog_keypad_debouncer_top import akd_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_W-1:0]        s_adc_sample,
    input  logic [TIME_W-1:0]          s_now_ms,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [KEY_W-1:0]    m_stable_key_out,
    output logic                       m_press_event,
    output logic [KEY_IDX_W-1:0]       m_pressed_key,
    output logic                       m_release_event,
    output logic [KEY_IDX_W-1:0]       m_released_key,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [SAMPLE_W-1:0]   window_reg;
    level_arr_t            level_reg;

    logic                  in_valid_reg, in_valid_next;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [TIME_W-1:0]     now_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg;

    logic                  s_accept;
    logic                  advance;
    key_t                  raw_key;
    result_t               result;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            window_reg   <= WINDOW_RESET;
            for (int i = 0; i < LEVEL_SLOTS; i++) begin
                level_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_DEBOUNCE_MS) begin
                debounce_reg <= cfg_wdata[DEBOUNCE_W-1:0];
            end
            if (cfg_index == REG_MATCH_WINDOW) begin
                window_reg <= cfg_wdata[SAMPLE_W-1:0];
            end
            for (int i = 0; i < LEVEL_SLOTS; i++) begin
                if (cfg_index == CFG_IDX_W'(REG_LEVEL_KEY0 + i)) begin
                    level_reg[i] <= cfg_wdata[SAMPLE_W-1:0];
                end
            end
        end
    end

    // input register moves on whenever the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= s_adc_sample;
            now_reg    <= s_now_ms;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    akd_matcher u_matcher (
        .sample       (sample_reg),
        .match_window (window_reg),
        .levels       (level_reg),
        .raw_key      (raw_key)
    );

    akd_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .raw_key     (raw_key),
        .now_ms      (now_reg),
        .debounce_ms (debounce_reg),
        .result      (result)
    );

    assign m_valid          = out_valid_reg;
    assign m_stable_key_out = out_reg.settled_key;
    assign m_press_event    = out_reg.press_event;
    assign m_pressed_key    = out_reg.pressed_key;
    assign m_release_event  = out_reg.release_event;
    assign m_released_key   = out_reg.released_key;

    `AKD_ASSERT_IMPL(a_press_is_stable, m_valid && m_press_event, m_stable_key_out == {1'b0, m_pressed_key}, "press word does not match stable key")
    `AKD_ASSERT_IMPL(a_swap_differs, m_valid && m_press_event && m_release_event, m_pressed_key != m_released_key, "release and press name the same key")
    `AKD_ASSERT_IMPL(a_full_blocks_input, in_valid_reg && out_valid_reg && !m_ready, !s_ready, "input taken while both registers are held")
    `AKD_ASSERT_NEXT(a_step_fills_output, advance, out_valid_reg, "stepped word did not reach the result register")

endmodule
